### hdl/significant_bit_rotate_right_assert.svh
// Assertion helpers used by the top-level design file.
`ifndef SIGNIFICANT_BIT_ROTATE_RIGHT_ASSERT_SVH
`define SIGNIFICANT_BIT_ROTATE_RIGHT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBRR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sbrr_pkg.sv
package sbrr_pkg;

  localparam int AMT_W = 31;
  // Amount bits consumed by each remainder stage.
  localparam int MOD_STEP = 4;
  localparam int MOD_STAGES = (AMT_W + MOD_STEP - 1) / MOD_STEP;
  localparam int AMT_PAD_W = MOD_STAGES * MOD_STEP;

endpackage

### hdl/sbrr_lead.sv
module sbrr_lead import sbrr_pkg::*; #(
  parameter int WIDTH = 20,
  parameter int LW = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_value,
  input  logic [AMT_W-1:0] in_amount,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_value,
  output logic [AMT_W-1:0] out_amount,
  output logic [LW-1:0]    out_len
);

  logic [LW-1:0] len_next;

  // Significant length is the position of the highest set bit plus one.
  always_comb begin
    len_next = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (in_value[i]) begin
        len_next = LW'(i + 1);
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_value  <= in_value;
      out_amount <= in_amount;
      out_len    <= len_next;
    end
  end

endmodule

### hdl/sbrr_mod_stage.sv
module sbrr_mod_stage import sbrr_pkg::*; #(
  parameter int WIDTH = 20,
  parameter int LW = 5,
  parameter int RW = 5,
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_value,
  input  logic [AMT_W-1:0] in_amount,
  input  logic [LW-1:0]    in_len,
  input  logic [RW-1:0]    in_rem,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_value,
  output logic [AMT_W-1:0] out_amount,
  output logic [LW-1:0]    out_len,
  output logic [RW-1:0]    out_rem
);

  logic [AMT_PAD_W-1:0] amt_pad;
  logic [RW:0]          part;
  logic [RW:0]          divisor;
  logic [RW-1:0]        rem_next;

  assign amt_pad = AMT_PAD_W'(in_amount);
  assign divisor = (RW + 1)'(in_len);

  // Restoring remainder, MSB first: shift in one amount bit, subtract if it fits.
  // While the remainder is below the length it always fits in RW bits.
  always_comb begin
    rem_next = in_rem;
    part     = '0;
    for (int j = 0; j < MOD_STEP; j++) begin
      part = {rem_next, amt_pad[AMT_PAD_W - 1 - STAGE * MOD_STEP - j]};
      if (part >= divisor) begin
        part = part - divisor;
      end
      rem_next = part[RW-1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_value  <= in_value;
      out_amount <= in_amount;
      out_len    <= in_len;
      out_rem    <= rem_next;
    end
  end

endmodule

### hdl/sbrr_rotate.sv
module sbrr_rotate #(
  parameter int WIDTH = 20,
  parameter int LW = 5,
  parameter int RW = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_value,
  input  logic [LW-1:0]    in_len,
  input  logic [RW-1:0]    in_rem,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_rotated
);

  logic [LW-1:0]    back;
  logic [WIDTH-1:0] mask;
  logic [WIDTH-1:0] rotated_next;

  // Bits shifted out at the bottom come back in the top bits, up to bit len-1. A zero rotate
  // distance pushes the wrapped copy fully out of the mask.
  assign back         = in_len - LW'(in_rem);
  assign mask         = ~({WIDTH{1'b1}} << in_len);
  assign rotated_next = ((in_value >> in_rem) | (in_value << back)) & mask;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rotated <= rotated_next;
    end
  end

endmodule

### hdl/significant_bit_rotate_right.sv
// Pipeline: one leading-one stage, eight remainder stages of four amount bits each,
// and one rotate stage, passed in that order.
// Throughput: one transaction per cycle unless the output is stalled; every stage has
// its own valid bit and bubbles are squeezed out. Reset (synchronous, active high)
// clears all valid bits.
`include "significant_bit_rotate_right_assert.svh"

module significant_bit_rotate_right import sbrr_pkg::*; #(
  parameter int WIDTH = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] value,
  input  logic [AMT_W-1:0] amount,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] rotated
);

  localparam int LW = $clog2(WIDTH + 1);
  localparam int RW = $clog2(WIDTH);

  logic             m_valid  [MOD_STAGES+1];
  logic             m_ready  [MOD_STAGES+1];
  logic [WIDTH-1:0] m_value  [MOD_STAGES+1];
  logic [AMT_W-1:0] m_amount [MOD_STAGES+1];
  logic [LW-1:0]    m_len    [MOD_STAGES+1];
  logic [RW-1:0]    m_rem    [MOD_STAGES+1];

  sbrr_lead #(
    .WIDTH (WIDTH),
    .LW    (LW)
  ) u_lead (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (value),
    .in_amount  (amount),
    .out_valid  (m_valid[0]),
    .out_ready  (m_ready[0]),
    .out_value  (m_value[0]),
    .out_amount (m_amount[0]),
    .out_len    (m_len[0])
  );

  assign m_rem[0] = '0;

  for (genvar s = 0; s < MOD_STAGES; s++) begin : g_mod
    sbrr_mod_stage #(
      .WIDTH (WIDTH),
      .LW    (LW),
      .RW    (RW),
      .STAGE (s)
    ) u_mod (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (m_valid[s]),
      .in_ready   (m_ready[s]),
      .in_value   (m_value[s]),
      .in_amount  (m_amount[s]),
      .in_len     (m_len[s]),
      .in_rem     (m_rem[s]),
      .out_valid  (m_valid[s+1]),
      .out_ready  (m_ready[s+1]),
      .out_value  (m_value[s+1]),
      .out_amount (m_amount[s+1]),
      .out_len    (m_len[s+1]),
      .out_rem    (m_rem[s+1])
    );
  end

  sbrr_rotate #(
    .WIDTH (WIDTH),
    .LW    (LW),
    .RW    (RW)
  ) u_rotate (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (m_valid[MOD_STAGES]),
    .in_ready    (m_ready[MOD_STAGES]),
    .in_value    (m_value[MOD_STAGES]),
    .in_len      (m_len[MOD_STAGES]),
    .in_rem      (m_rem[MOD_STAGES]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rotated (rotated)
  );

  // The length from the first stage must cover every set bit of the value.
  `SBRR_ASSERT_NOW(a_len_covers, clk, rst, m_valid[0], (m_value[0] >> m_len[0]) == '0, "length misses a set bit")

  // The final remainder must be below the length whenever the value is nonzero.
  `SBRR_ASSERT_NOW(a_rem_range, clk, rst, m_valid[MOD_STAGES] && (m_len[MOD_STAGES] != '0), m_rem[MOD_STAGES] < RW'(m_len[MOD_STAGES] - LW'(1)) || m_rem[MOD_STAGES] == RW'(m_len[MOD_STAGES] - LW'(1)), "remainder out of range")

  // An accepted transaction always lands in the first stage.
  `SBRR_ASSERT_NEXT(a_accept_lands, clk, rst, in_valid && in_ready, m_valid[0], "accepted transaction lost")

endmodule
